FILE: hw/rtl/lorentz_boost_assert.svh
// Assertion macros used by the checker file of the boost block, lb_check.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef LORENTZ_BOOST_ASSERT_SVH
`define LORENTZ_BOOST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lorentz_boost assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lorentz_boost assertion failed");

`endif

FILE: hw/rtl/lb_pkg.sv
// Shared types, constants and helper functions of the Lorentz boost block.
// Depends on nothing; used by lb_coef, lorentz_boost and lb_check.
package lb_pkg;

    localparam int VEC_W    = 40;
    localparam int BETA_W   = 32;
    localparam int G_W      = 41;
    localparam int PIPE_LAT = 8;
    localparam int RND_HALF = 536870912;

    localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;
    localparam logic [63:0] B2_LIMIT = 64'h0FFF_FF00_0000_0000;
    localparam logic [40:0] ONE_Q30  = 41'h000_4000_0000;

    typedef logic [1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_BETA_X = 2'd0;
    localparam t_cfg_addr CFG_BETA_Y = 2'd1;
    localparam t_cfg_addr CFG_BETA_Z = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_SAT  = 2'd1;
    localparam t_status ST_FAST = 2'd2;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SQ,
        CS_CHK,
        CS_SQRT,
        CS_DIV1,
        CS_DIV2
    } t_cstate;

    // Beta coefs; only users keep them stable while items are in flight.
    typedef struct packed {
        logic signed [BETA_W-1:0] bx;
        logic signed [BETA_W-1:0] by;
        logic signed [BETA_W-1:0] bz;
        logic [G_W-1:0]           g;
        logic [G_W-1:0]           g2;
        logic                     fast;
    } t_coef;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_007F_FFFF_FFFF;
    localparam logic signed [63:0] SAT_LO = -64'sh0000_0080_0000_0000;

    function automatic logic signed [VEC_W-1:0] sat_val(input logic signed [63:0] v);
        logic signed [VEC_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[VEC_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[VEC_W-1:0];
        end else begin
            res = v[VEC_W-1:0];
        end
        return res;
    endfunction

    function automatic logic sat_ovf(input logic signed [63:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

endpackage

FILE: hw/rtl/lorentz_boost.sv
// Top level of the general-direction Lorentz boost: velocity port and 8-stage datapath.
// Depends on lb_pkg and lb_coef.
//
// The block boosts one four-vector (t, x, y, z in signed Q23.16) per clock cycle
// while busy is low. A vector is transferred in when start is high and busy is
// low; its result appears at the outputs, marked by o_valid for exactly one
// cycle. The receiver cannot stall, so the pipeline never holds and vectors may
// enter back to back. Writing any velocity register starts the coefficient unit,
// which squares the three components one at a time and, unless the sum is zero
// or too large, takes a 32-step square root and two 62-step divisions; busy stays
// high until the coefficients are set and no vector is transferred in meanwhile.
// ST_FAST means the velocity squared exceeds 1 - 2^-20 and the result vector is
// zero; ST_SAT means at least one output component was clamped to 40 bits.
module lorentz_boost
    import lb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  t_cfg_addr               i_cfg_addr,
    input  logic [BETA_W-1:0]       i_cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VEC_W-1:0] i_energy_in,
    input  logic signed [VEC_W-1:0] i_mom_x_in,
    input  logic signed [VEC_W-1:0] i_mom_y_in,
    input  logic signed [VEC_W-1:0] i_mom_z_in,
    output logic                    o_valid,
    output logic signed [VEC_W-1:0] o_energy_out,
    output logic signed [VEC_W-1:0] o_mom_x_out,
    output logic signed [VEC_W-1:0] o_mom_y_out,
    output logic signed [VEC_W-1:0] o_mom_z_out,
    output t_status                 o_status
);

    t_coef coef;
    logic  coef_busy;

    lb_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_coef     (coef),
        .o_busy     (coef_busy)
    );

    assign busy = coef_busy;

    logic accept;
    assign accept = start && !coef_busy;

    logic signed [G_W:0] gs, g2s;
    assign gs  = $signed({1'b0, coef.g});
    assign g2s = $signed({1'b0, coef.g2});

    // Valid bits travel with the data; x, y and z ride along until stage 8.
    logic [PIPE_LAT:1] r_vld;
    logic signed [VEC_W-1:0] r_x [1:PIPE_LAT-1];
    logic signed [VEC_W-1:0] r_y [1:PIPE_LAT-1];
    logic signed [VEC_W-1:0] r_z [1:PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-1:1], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[1] <= i_mom_x_in;
        r_y[1] <= i_mom_y_in;
        r_z[1] <= i_mom_z_in;
        for (int k = 2; k < PIPE_LAT; k++) begin
            r_x[k] <= r_x[k-1];
            r_y[k] <= r_y[k-1];
            r_z[k] <= r_z[k-1];
        end
    end

    // Stage 1: partial products of beta.p and gamma*t, each input split at bit 20.
    logic signed [52:0] r1_xl, r1_yl, r1_zl;
    logic signed [51:0] r1_xh, r1_yh, r1_zh;
    logic signed [62:0] r1_tl;
    logic signed [61:0] r1_th;

    always_ff @(posedge i_clk) begin
        r1_xl <= $signed(coef.bx) * $signed({1'b0, i_mom_x_in[19:0]});
        r1_yl <= $signed(coef.by) * $signed({1'b0, i_mom_y_in[19:0]});
        r1_zl <= $signed(coef.bz) * $signed({1'b0, i_mom_z_in[19:0]});
        r1_xh <= $signed(coef.bx) * $signed(i_mom_x_in[39:20]);
        r1_yh <= $signed(coef.by) * $signed(i_mom_y_in[39:20]);
        r1_zh <= $signed(coef.bz) * $signed(i_mom_z_in[39:20]);
        r1_tl <= gs * $signed({1'b0, i_energy_in[19:0]});
        r1_th <= gs * $signed(i_energy_in[39:20]);
    end

    // Stage 2: join the halves into full products.
    logic signed [71:0] r2_px, r2_py, r2_pz;
    logic signed [81:0] r2_gt;

    always_ff @(posedge i_clk) begin
        r2_px <= (72'(r1_xh) <<< 20) + 72'(r1_xl);
        r2_py <= (72'(r1_yh) <<< 20) + 72'(r1_yl);
        r2_pz <= (72'(r1_zh) <<< 20) + 72'(r1_zl);
        r2_gt <= (82'(r1_th) <<< 20) + 82'(r1_tl);
    end

    // Stage 3: bp = beta.p rounded from Q.46 to Q.16.
    logic signed [73:0] bp_sum;
    logic signed [43:0] r3_bp;
    logic signed [81:0] r3_gt;

    assign bp_sum = 74'(r2_px) + 74'(r2_py) + 74'(r2_pz) + 74'(RND_HALF);

    always_ff @(posedge i_clk) begin
        r3_bp <= 44'(bp_sum >>> 30);
        r3_gt <= r2_gt;
    end

    // Stage 4: gamma*bp and gamma2*bp, bp split at bit 22.
    logic signed [64:0] r4_gl, r4_g2l;
    logic signed [63:0] r4_gh, r4_g2h;
    logic signed [81:0] r4_gt;

    always_ff @(posedge i_clk) begin
        r4_gl  <= gs  * $signed({1'b0, r3_bp[21:0]});
        r4_gh  <= gs  * $signed(r3_bp[43:22]);
        r4_g2l <= g2s * $signed({1'b0, r3_bp[21:0]});
        r4_g2h <= g2s * $signed(r3_bp[43:22]);
        r4_gt  <= r3_gt;
    end

    // Stage 5: join the halves.
    logic signed [87:0] r5_gbp, r5_g2bp;
    logic signed [81:0] r5_gt;

    always_ff @(posedge i_clk) begin
        r5_gbp  <= (88'(r4_gh) <<< 22) + 88'(r4_gl);
        r5_g2bp <= (88'(r4_g2h) <<< 22) + 88'(r4_g2l);
        r5_gt   <= r4_gt;
    end

    // Stage 6: w = gamma2*bp + gamma*t, and t' = gamma*t + gamma*bp, both rounded.
    logic signed [87:0] w_sum, e_sum;
    logic signed [63:0] e_val;
    logic signed [55:0] r6_w;
    logic signed [VEC_W-1:0] r6_e;
    logic r6_esat;

    assign w_sum = r5_g2bp + 88'(r5_gt) + 88'(RND_HALF);
    assign e_sum = r5_gbp + 88'(r5_gt) + 88'(RND_HALF);
    assign e_val = 64'(e_sum >>> 30);

    always_ff @(posedge i_clk) begin
        r6_w    <= 56'(w_sum >>> 30);
        r6_e    <= sat_val(e_val);
        r6_esat <= sat_ovf(e_val);
    end

    // Stage 7: w*beta for each axis, w split at bit 28.
    logic signed [60:0] r7_xl, r7_yl, r7_zl;
    logic signed [59:0] r7_xh, r7_yh, r7_zh;
    logic signed [VEC_W-1:0] r7_e;
    logic r7_esat;

    always_ff @(posedge i_clk) begin
        r7_xl   <= $signed(coef.bx) * $signed({1'b0, r6_w[27:0]});
        r7_yl   <= $signed(coef.by) * $signed({1'b0, r6_w[27:0]});
        r7_zl   <= $signed(coef.bz) * $signed({1'b0, r6_w[27:0]});
        r7_xh   <= $signed(coef.bx) * $signed(r6_w[55:28]);
        r7_yh   <= $signed(coef.by) * $signed(r6_w[55:28]);
        r7_zh   <= $signed(coef.bz) * $signed(r6_w[55:28]);
        r7_e    <= r6_e;
        r7_esat <= r6_esat;
    end

    // Stage 8: round the shifts, add them to the spatial part and saturate, or give zero when fast is set.
    logic signed [87:0] dx_sum, dy_sum, dz_sum;
    logic signed [63:0] x_val, y_val, z_val;
    logic any_sat;

    assign dx_sum = (88'(r7_xh) <<< 28) + 88'(r7_xl) + 88'(RND_HALF);
    assign dy_sum = (88'(r7_yh) <<< 28) + 88'(r7_yl) + 88'(RND_HALF);
    assign dz_sum = (88'(r7_zh) <<< 28) + 88'(r7_zl) + 88'(RND_HALF);
    assign x_val  = 64'(dx_sum >>> 30) + 64'(r_x[PIPE_LAT-1]);
    assign y_val  = 64'(dy_sum >>> 30) + 64'(r_y[PIPE_LAT-1]);
    assign z_val  = 64'(dz_sum >>> 30) + 64'(r_z[PIPE_LAT-1]);
    assign any_sat = r7_esat || sat_ovf(x_val) || sat_ovf(y_val) || sat_ovf(z_val);

    logic signed [VEC_W-1:0] r_eo, r_xo, r_yo, r_zo;
    t_status r_st;

    always_ff @(posedge i_clk) begin
        if (coef.fast) begin
            r_eo <= '0;
            r_xo <= '0;
            r_yo <= '0;
            r_zo <= '0;
            r_st <= ST_FAST;
        end else begin
            r_eo <= r7_e;
            r_xo <= sat_val(x_val);
            r_yo <= sat_val(y_val);
            r_zo <= sat_val(z_val);
            r_st <= any_sat ? ST_SAT : ST_OK;
        end
    end

    assign o_valid      = r_vld[PIPE_LAT];
    assign o_energy_out = r_eo;
    assign o_mom_x_out  = r_xo;
    assign o_mom_y_out  = r_yo;
    assign o_mom_z_out  = r_zo;
    assign o_status     = r_st;

endmodule

FILE: hw/rtl/lb_coef.sv
// Velocity registers and the sequential unit that derives gamma and gamma2.
// Depends on lb_pkg; one shared squarer, a bit-serial square root and divider.
module lb_coef
    import lb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_addr         i_cfg_addr,
    input  logic [BETA_W-1:0] i_cfg_data,
    output t_coef             o_coef,
    output logic              o_busy
);

    t_cstate            r_state, n_state;
    logic signed [BETA_W-1:0] r_bx, r_by, r_bz, n_bx, n_by, n_bz;
    logic [5:0]         r_cnt, n_cnt;
    logic [63:0]        r_b2, n_b2;
    logic [63:0]        r_v, n_v, r_r, n_r, r_bit, n_bit;
    logic [61:0]        r_num, n_num, r_quo, n_quo;
    logic [41:0]        r_den, n_den;
    logic [42:0]        r_rem, n_rem;
    logic [G_W-1:0]     r_g, n_g, r_cg, n_cg, r_cg2, n_cg2;
    logic               r_fast, n_fast;

    logic signed [BETA_W-1:0] sq_sel;
    logic signed [63:0] sq_prod;
    logic [63:0]        rt_sum;
    logic [42:0]        rem_sh;
    logic               rem_ge;
    logic [42:0]        rem_nx;
    logic [61:0]        quo_nx;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_sel = r_bx;
            2'd1:    sq_sel = r_by;
            default: sq_sel = r_bz;
        endcase
        sq_prod = sq_sel * sq_sel;
        rt_sum  = r_r + r_bit;
        rem_sh  = {r_rem[41:0], r_num[61]};
        rem_ge  = rem_sh >= {1'b0, r_den};
        rem_nx  = rem_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        quo_nx  = {r_quo[60:0], rem_ge};
    end

    always_comb begin
        n_state = r_state;
        n_bx = r_bx; n_by = r_by; n_bz = r_bz;
        n_cnt = r_cnt; n_b2 = r_b2;
        n_v = r_v; n_r = r_r; n_bit = r_bit;
        n_num = r_num; n_quo = r_quo; n_den = r_den; n_rem = r_rem;
        n_g = r_g; n_cg = r_cg; n_cg2 = r_cg2; n_fast = r_fast;
        unique case (r_state)
            CS_IDLE: ;
            CS_SQ: begin
                n_b2  = r_b2 + sq_prod;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd2) begin
                    n_state = CS_CHK;
                end
            end
            CS_CHK: begin
                if (r_b2 > B2_LIMIT || r_b2 == 64'd0) begin
                    n_fast  = r_b2 > B2_LIMIT;
                    n_cg    = ONE_Q30;
                    n_cg2   = '0;
                    n_state = CS_IDLE;
                end else begin
                    n_v     = (ONE_Q60 - r_b2) << 2;
                    n_r     = '0;
                    n_bit   = 64'd1 << 62;
                    n_state = CS_SQRT;
                end
            end
            CS_SQRT: begin
                if (r_v >= rt_sum) begin
                    n_v = r_v - rt_sum;
                    n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == 64'd1) begin
                    n_den   = n_r[41:0];
                    n_num   = 62'd1 << 61;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = 6'd61;
                    n_state = CS_DIV1;
                end
            end
            CS_DIV1: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_num = r_num << 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_g     = quo_nx[G_W-1:0];
                    n_den   = {1'b0, quo_nx[G_W-1:0]} + {1'b0, ONE_Q30};
                    n_num   = 62'd1 << 60;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = 6'd61;
                    n_state = CS_DIV2;
                end
            end
            CS_DIV2: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_num = r_num << 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_cg    = r_g;
                    n_cg2   = r_g - ONE_Q30 + quo_nx[G_W-1:0];
                    n_fast  = 1'b0;
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
        // A register write restarts the derivation from the new velocity.
        if (i_cfg_we && (i_cfg_addr == CFG_BETA_X || i_cfg_addr == CFG_BETA_Y
                         || i_cfg_addr == CFG_BETA_Z)) begin
            if (i_cfg_addr == CFG_BETA_X) n_bx = i_cfg_data;
            if (i_cfg_addr == CFG_BETA_Y) n_by = i_cfg_data;
            if (i_cfg_addr == CFG_BETA_Z) n_bz = i_cfg_data;
            n_cnt   = '0;
            n_b2    = '0;
            n_state = CS_SQ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_bx    <= '0;
            r_by    <= '0;
            r_bz    <= '0;
            r_cg    <= ONE_Q30;
            r_cg2   <= '0;
            r_fast  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_bz    <= n_bz;
            r_cg    <= n_cg;
            r_cg2   <= n_cg2;
            r_fast  <= n_fast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_b2  <= n_b2;
        r_v   <= n_v;
        r_r   <= n_r;
        r_bit <= n_bit;
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
        r_rem <= n_rem;
        r_g   <= n_g;
    end

    assign o_coef = '{bx: r_bx, by: r_by, bz: r_bz, g: r_cg, g2: r_cg2, fast: r_fast};
    assign o_busy = r_state != CS_IDLE;

endmodule

FILE: hw/rtl/lb_check.sv
// Port-level checker for the Lorentz boost block, attached by bind.
// Depends on lb_pkg and the macros in lorentz_boost_assert.svh.
`include "lorentz_boost_assert.svh"

module lb_check
    import lb_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input t_cfg_addr               i_cfg_addr,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic signed [VEC_W-1:0] o_energy_out,
    input logic signed [VEC_W-1:0] o_mom_x_out,
    input t_status                 o_status
);

    // Every accepted vector yields exactly one result after the pipeline latency.
    `LB_ASSERT_IMP(a_lat_fwd, i_clk, i_rst_n, start && !busy, ##PIPE_LAT o_valid)
    `LB_ASSERT_IMP(a_lat_back, i_clk, i_rst_n, o_valid, $past(start && !busy, PIPE_LAT))
    // A too-fast velocity zeroes the vector.
    `LB_ASSERT_IMP(a_fast_zero, i_clk, i_rst_n, o_valid && o_status == ST_FAST,
        o_energy_out == '0 && o_mom_x_out == '0)
    // A velocity write always starts the coefficient unit.
    `LB_ASSERT_NXT(a_cfg_busy, i_clk, i_rst_n,
        i_cfg_we && (i_cfg_addr == CFG_BETA_X || i_cfg_addr == CFG_BETA_Y
        || i_cfg_addr == CFG_BETA_Z), busy)

endmodule

bind lorentz_boost lb_check u_lb_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_addr   (i_cfg_addr),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_energy_out (o_energy_out),
    .o_mom_x_out  (o_mom_x_out),
    .o_status     (o_status)
);

FILE: tb/tb_top.sv
// Self-checking testbench of the general-direction Lorentz boost block.
// Depends on lb_pkg and lorentz_boost; drives vectors and velocity writes and checks every result.
`timescale 1ns / 100ps

module tb_top;
    import lb_pkg::*;

    localparam int        CLK_HALF   = 6;
    localparam int        CYCLE_MAX  = 400000;
    localparam int        N_PHASES   = 10;
    localparam int        PHASE_LEN  = 55;
    localparam t_cfg_addr CFG_UNUSED = 2'd3;

    localparam logic signed [VEC_W-1:0] VEC_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [VEC_W-1:0] VEC_MIN = 40'sh80_0000_0000;

    // One boosted four-vector with its status, as the block reports it.
    typedef struct {
        logic signed [VEC_W-1:0] t;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        t_status                 st;
    } t_boosted;

    // A row of the directed table: either a velocity write or a vector.
    // Where typed is set, the expected result is given in the row itself.
    typedef struct {
        bit                      cfg;
        t_cfg_addr               addr;
        logic [BETA_W-1:0]       data;
        logic signed [VEC_W-1:0] t;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        bit                      typed;
        t_boosted                res;
    } t_dir_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    t_cfg_addr               i_cfg_addr;
    logic [BETA_W-1:0]       i_cfg_data;
    logic                    start;
    logic                    busy;
    logic signed [VEC_W-1:0] i_energy_in;
    logic signed [VEC_W-1:0] i_mom_x_in;
    logic signed [VEC_W-1:0] i_mom_y_in;
    logic signed [VEC_W-1:0] i_mom_z_in;
    logic                    o_valid;
    logic signed [VEC_W-1:0] o_energy_out;
    logic signed [VEC_W-1:0] o_mom_x_out;
    logic signed [VEC_W-1:0] o_mom_y_out;
    logic signed [VEC_W-1:0] o_mom_z_out;
    t_status                 o_status;

    // Our own copy of the velocity registers, updated on every write.
    logic [BETA_W-1:0] vel_x, vel_y, vel_z;

    t_boosted boosted_q[$];
    t_dir_row dir_rows[$];
    int       n_errors = 0;
    int       n_cycles = 0;

    lorentz_boost dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .start        (start),
        .busy         (busy),
        .i_energy_in  (i_energy_in),
        .i_mom_x_in   (i_mom_x_in),
        .i_mom_y_in   (i_mom_y_in),
        .i_mom_z_in   (i_mom_z_in),
        .o_valid      (o_valid),
        .o_energy_out (o_energy_out),
        .o_mom_x_out  (o_mom_x_out),
        .o_mom_y_out  (o_mom_y_out),
        .o_mom_z_out  (o_mom_z_out),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Round a Q.46 product to Q.16: add one half and shift right, rounding half up.
    function automatic logic signed [127:0] round_q46(input logic signed [127:0] a);
        return (a + 128'sd536870912) >>> 30;
    endfunction

    // Clamp to the signed 64-bit range.
    function automatic logic signed [127:0] clamp64(input logic signed [127:0] a);
        if (a > 128'sh7FFF_FFFF_FFFF_FFFF) begin
            return 128'sh7FFF_FFFF_FFFF_FFFF;
        end else if (a < -128'sh8000_0000_0000_0000) begin
            return -128'sh8000_0000_0000_0000;
        end
        return a;
    endfunction

    // Clamp to the 40-bit output range and note whether anything was clipped.
    function automatic logic signed [VEC_W-1:0] clamp_out(input logic signed [127:0] a,
                                                           inout bit clipped);
        if (a > 128'sh7F_FFFF_FFFF) begin
            clipped = 1'b1;
            return VEC_MAX;
        end else if (a < -128'sh80_0000_0000) begin
            clipped = 1'b1;
            return VEC_MIN;
        end
        return a[VEC_W-1:0];
    endfunction

    // Boosted vector for the current velocity registers.
    function automatic t_boosted boost_vec(input logic signed [VEC_W-1:0] t,
                                           input logic signed [VEC_W-1:0] x,
                                           input logic signed [VEC_W-1:0] y,
                                           input logic signed [VEC_W-1:0] z);
        t_boosted               r;
        logic signed [127:0]    bx, by, bz, tt, xx, yy, zz, bp, w, gs, g2s;
        logic [127:0]           b2, rem, root, bit_w, g, g2;
        bit                     clipped;
        bx = $signed(vel_x);
        by = $signed(vel_y);
        bz = $signed(vel_z);
        tt = t;
        xx = x;
        yy = y;
        zz = z;
        clipped = 1'b0;
        b2 = bx * bx + by * by + bz * bz;
        if (b2 > {64'd0, B2_LIMIT}) begin
            r = '{t: '0, x: '0, y: '0, z: '0, st: ST_FAST};
            return r;
        end
        // Integer square root of 4*(1 - b2), bit by bit.
        rem   = ((128'd1 << 60) - b2) << 2;
        root  = '0;
        bit_w = 128'd1 << 62;
        while (bit_w > rem) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
                rem  = rem - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        g  = (128'd1 << 61) / root;
        g2 = (b2 == 0) ? 128'd0 : g - (128'd1 << 30) + (128'd1 << 60) / (g + (128'd1 << 30));
        gs  = $signed(g);
        g2s = $signed(g2);
        bp  = clamp64(round_q46(bx * xx + by * yy + bz * zz));
        w   = clamp64(round_q46(g2s * bp + gs * tt));
        r.x = clamp_out(xx + round_q46(w * bx), clipped);
        r.y = clamp_out(yy + round_q46(w * by), clipped);
        r.z = clamp_out(zz + round_q46(w * bz), clipped);
        r.t = clamp_out(round_q46(gs * (tt + bp)), clipped);
        r.st = clipped ? ST_SAT : ST_OK;
        return r;
    endfunction

    // Wait until every expected result is back and the pipeline has emptied.
    task automatic wait_drained();
        while (boosted_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // Velocity writes, one per cycle, made only while no vector is in flight.
    task automatic write_velocity(input t_cfg_addr addr, input logic [BETA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_BETA_X: vel_x = data;
            CFG_BETA_Y: vel_y = data;
            CFG_BETA_Z: vel_z = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        // Give the coefficient unit a moment to raise busy before vectors are offered.
        repeat (2) @(posedge i_clk);
    endtask

    // Offer one vector after a gap, hold it until the transfer, then queue its result.
    // Start stays high when the next vector follows without a gap.
    task automatic send_vec(input logic signed [VEC_W-1:0] t, input logic signed [VEC_W-1:0] x,
                            input logic signed [VEC_W-1:0] y, input logic signed [VEC_W-1:0] z,
                            input int gap, input bit typed, input t_boosted res);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_energy_in <= t;
        i_mom_x_in  <= x;
        i_mom_y_in  <= y;
        i_mom_z_in  <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        boosted_q.push_back(typed ? res : boost_vec(t, x, y, z));
    endtask

    function automatic logic signed [VEC_W-1:0] rand_field(input int mode);
        logic signed [VEC_W-1:0] v;
        case (mode)
            0: v = {8'($urandom_range(255)), 32'($urandom)};
            1: v = $signed(40'($urandom_range(33554431))) - 40'sd16777216;
            default: begin
                case ($urandom_range(3))
                    0: v = VEC_MAX;
                    1: v = VEC_MIN;
                    2: v = '0;
                    default: v = -40'sd1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [BETA_W-1:0] rand_beta(input int mode);
        logic [BETA_W-1:0] b;
        case (mode)
            0: b = 32'($signed(32'($urandom_range(536870911))) - 268435456);
            1: b = 32'($signed(32'($urandom_range(1073741823))) - 536870912);
            2: b = $urandom();
            default: b = '0;
        endcase
        return b;
    endfunction

    // Results come for exactly one cycle and cannot be held off, so every
    // strobe is checked against the oldest expectation at the edge it ends on.
    always @(posedge i_clk) begin
        t_boosted want;
        if (i_rst_n && o_valid) begin
            if (boosted_q.size() == 0) begin
                $display("%0t: unexpected result t=%h x=%h y=%h z=%h status=%0d", $time,
                         o_energy_out, o_mom_x_out, o_mom_y_out, o_mom_z_out, o_status);
                n_errors = n_errors + 1;
            end else begin
                want = boosted_q.pop_front();
                if (o_energy_out !== want.t) begin
                    $display("%0t: energy expected %h actual %h", $time, want.t, o_energy_out);
                    n_errors = n_errors + 1;
                end
                if (o_mom_x_out !== want.x) begin
                    $display("%0t: mom_x expected %h actual %h", $time, want.x, o_mom_x_out);
                    n_errors = n_errors + 1;
                end
                if (o_mom_y_out !== want.y) begin
                    $display("%0t: mom_y expected %h actual %h", $time, want.y, o_mom_y_out);
                    n_errors = n_errors + 1;
                end
                if (o_mom_z_out !== want.z) begin
                    $display("%0t: mom_z expected %h actual %h", $time, want.z, o_mom_z_out);
                    n_errors = n_errors + 1;
                end
                if (o_status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, o_status);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    // A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_MAX) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        t_boosted pass_thru, zero_fast, none;
        t_dir_row row;
        int       beta_mode, vec_mode, gap;
        bit       bursty;
        vel_x       = '0;
        vel_y       = '0;
        vel_z       = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_BETA_X;
        i_cfg_data  = '0;
        start       = 1'b0;
        i_energy_in = '0;
        i_mom_x_in  = '0;
        i_mom_y_in  = '0;
        i_mom_z_in  = '0;
        none        = '{t: '0, x: '0, y: '0, z: '0, st: ST_OK};
        zero_fast   = '{t: '0, x: '0, y: '0, z: '0, st: ST_FAST};

        // Directed table. With zero velocity the vector passes unchanged, and any
        // velocity at or beyond the light-speed limit gives a zero vector.
        pass_thru = '{t: VEC_MAX, x: VEC_MAX, y: VEC_MAX, z: VEC_MAX, st: ST_OK};
        dir_rows.push_back('{0, CFG_BETA_X, 0, VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, 1, pass_thru});
        pass_thru = '{t: VEC_MIN, x: VEC_MIN, y: VEC_MIN, z: VEC_MIN, st: ST_OK};
        dir_rows.push_back('{0, CFG_BETA_X, 0, VEC_MIN, VEC_MIN, VEC_MIN, VEC_MIN, 1, pass_thru});
        dir_rows.push_back('{0, CFG_BETA_X, 0, 0, 0, 0, 0, 1, none});
        pass_thru = '{t: 40'sd1, x: -40'sd1, y: VEC_MAX, z: VEC_MIN, st: ST_OK};
        dir_rows.push_back('{0, CFG_BETA_X, 0, 1, -1, VEC_MAX, VEC_MIN, 1, pass_thru});
        dir_rows.push_back('{1, CFG_BETA_X, 32'h4000_0000, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, 65536, 65536, 0, 0, 1, zero_fast});
        dir_rows.push_back('{1, CFG_BETA_X, 32'h8000_0000, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, VEC_MAX, VEC_MIN, 5, 7, 1, zero_fast});
        dir_rows.push_back('{1, CFG_BETA_X, 32'hC000_0000, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, VEC_MIN, 3, VEC_MAX, 1, 1, zero_fast});
        dir_rows.push_back('{1, CFG_BETA_X, 32'h0000_0000, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{1, CFG_BETA_Y, 32'h4000_0000, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, 65536, 0, 65536, 0, 1, zero_fast});
        dir_rows.push_back('{1, CFG_BETA_Y, 32'h0000_0000, 0, 0, 0, 0, 0, none});
        // Just above the limit, then just below it where gamma is near its largest.
        dir_rows.push_back('{1, CFG_BETA_Z, 32'h3FFF_FE00, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, 65536, 0, 0, 65536, 1, zero_fast});
        dir_rows.push_back('{1, CFG_BETA_Z, 32'h3FFF_FC00, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, 65536, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, 0, none});
        dir_rows.push_back('{1, CFG_BETA_Z, 32'h0000_0000, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{1, CFG_BETA_X, 32'h2666_6666, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{1, CFG_BETA_Y, 32'hE000_0000, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, 655360, -327680, 131072, 9, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, VEC_MAX, VEC_MAX, VEC_MIN, 0, 0, none});
        // A write to the unused index must leave the velocity alone.
        dir_rows.push_back('{1, CFG_UNUSED, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, none});
        dir_rows.push_back('{0, CFG_BETA_X, 0, -40'sd655360, 1, 2, 3, 0, none});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.cfg) begin
                start <= 1'b0;
                wait_drained();
                write_velocity(row.addr, row.data);
                end_writes();
            end else begin
                send_vec(row.t, row.x, row.y, row.z, $urandom_range(1), row.typed, row.res);
            end
        end

        // Random part: a new velocity per phase, some phases without any gaps.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            start <= 1'b0;
            wait_drained();
            beta_mode = (ph == 3) ? 3 : ph % 3;
            write_velocity(CFG_BETA_X, rand_beta(beta_mode));
            write_velocity(CFG_BETA_Y, rand_beta(beta_mode));
            write_velocity(CFG_BETA_Z, rand_beta(beta_mode));
            end_writes();
            bursty = (ph == 0) || ($urandom_range(2) == 0);
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (ph == 4 && k == 20) begin
                    // Hold off new vectors until the pipeline has handed back everything.
                    start <= 1'b0;
                    while (boosted_q.size() != 0) @(posedge i_clk);
                end
                vec_mode = $urandom_range(9);
                vec_mode = (vec_mode < 6) ? 0 : (vec_mode < 9) ? 1 : 2;
                gap = bursty ? 0 : $urandom_range(5);
                send_vec(rand_field(vec_mode), rand_field(vec_mode), rand_field(vec_mode),
                         rand_field(vec_mode), gap, 1'b0, none);
            end
        end

        start <= 1'b0;
        wait_drained();
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
